### sv/cbl_pkg.sv
// ----------------------------------------------------------------------------
// cbl_pkg: shared types and codes of the clipped rectangle blitter
// Command codes, register indexes, the job passed from front to back,
// the result item and the configuration bundle.
// ----------------------------------------------------------------------------
package cbl_pkg;

  localparam logic [2:0] CMD_READ  = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_FILL  = 3'd2;
  localparam logic [2:0] CMD_REMAP = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;
  localparam logic [2:0] CMD_LOAD  = 3'd5;

  localparam logic [2:0] CFG_BASE     = 3'd0;
  localparam logic [2:0] CFG_WIDTH    = 3'd1;
  localparam logic [2:0] CFG_HEIGHT   = 3'd2;
  localparam logic [2:0] CFG_STRIDE   = 3'd3;
  localparam logic [2:0] CFG_REMAP_EN = 3'd4;

  localparam logic [29:0] COUNT_LIMIT = 30'd16384;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_READ  = 3'd1,
    OP_FILL  = 3'd2,
    OP_REMAP = 3'd3,
    OP_LOAD  = 3'd4
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [14:0] w;
    logic [14:0] h;
    logic [14:0] count;
    logic [7:0]  color;
    logic [7:0]  tidx;
    logic [7:0]  tval;
  } job_t;

  typedef struct packed {
    logic [7:0]  read_value;
    logic [14:0] pixels_changed;
  } res_t;

  typedef struct packed {
    logic [13:0] base;
    logic [14:0] width;
    logic [14:0] height;
    logic [13:0] stride;
    logic        remap_en;
  } cfg_t;

endpackage

### sv/cbl_ram.sv
// ----------------------------------------------------------------------------
// cbl_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cbl_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### sv/cbl_fifo.sv
// ----------------------------------------------------------------------------
// cbl_fifo: small register queue
// Decouples two sides; data at the head is shown while empty is low.
// ----------------------------------------------------------------------------
module cbl_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### sv/cbl_front.sv
// ----------------------------------------------------------------------------
// cbl_front: command decode and clipping
// Classifies each command, clips its rectangle against the viewport,
// then forms the start address and the saturated write count.
// ----------------------------------------------------------------------------
module cbl_front import cbl_pkg::*; #(
  parameter int AW = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         command,
  input  logic signed [15:0] x,
  input  logic signed [15:0] y,
  input  logic signed [15:0] end_x,
  input  logic signed [15:0] end_y,
  input  logic signed [15:0] span_width,
  input  logic signed [15:0] span_height,
  input  logic [7:0]         color,
  input  logic [7:0]         table_index,
  input  logic [7:0]         table_value,
  output logic               job_valid,
  input  logic               job_ready,
  output job_t               job,
  output logic [AW-1:0]      job_addr
);

  typedef struct packed {
    op_t         op;
    logic [14:0] x0;
    logic [14:0] y0;
    logic [14:0] w;
    logic [14:0] h;
    logic [7:0]  color;
    logic [7:0]  tidx;
    logic [7:0]  tval;
  } clip_t;

  logic signed [17:0] rx0, ry0, rx1, ry1, cx0, cy0, cx1, cy1, wlim, hlim, wdt, hgt;
  logic               reject, empty_rect;
  op_t                op;
  clip_t              s1_nxt, s1_r;
  logic               s1_v_r;
  logic [28:0]        row_off;
  logic [31:0]        addr_sum;
  logic [29:0]        area;

  always_comb begin
    wlim = 18'(cfg.width);
    hlim = 18'(cfg.height);
    rx0  = 18'(x);
    ry0  = 18'(y);
    rx1  = 18'(x);
    ry1  = 18'(y);
    op   = OP_NONE;
    case (command)
      CMD_READ: begin
        op = OP_READ;
      end
      CMD_WRITE: begin
        op = OP_FILL;
      end
      CMD_FILL: begin
        op  = OP_FILL;
        rx1 = 18'(end_x);
        ry1 = 18'(end_y);
      end
      CMD_REMAP: begin
        op  = cfg.remap_en ? OP_REMAP : OP_NONE;
        rx1 = 18'(x) + 18'(span_width) - 18'sd1;
        ry1 = 18'(y) + 18'(span_height) - 18'sd1;
      end
      CMD_CLEAR: begin
        op  = OP_FILL;
        rx0 = '0;
        ry0 = '0;
        rx1 = wlim - 18'sd1;
        ry1 = hlim - 18'sd1;
      end
      CMD_LOAD: begin
        op = OP_LOAD;
      end
      default: begin
        op = OP_NONE;
      end
    endcase

    reject     = (rx0 >= wlim) || (ry0 >= hlim) || (rx1 < 0) || (ry1 < 0);
    cx0        = (rx0 < 0) ? '0 : rx0;
    cy0        = (ry0 < 0) ? '0 : ry0;
    cx1        = (rx1 > wlim - 18'sd1) ? wlim - 18'sd1 : rx1;
    cy1        = (ry1 > hlim - 18'sd1) ? hlim - 18'sd1 : ry1;
    empty_rect = (cx1 < cx0) || (cy1 < cy0);
    wdt        = cx1 - cx0 + 18'sd1;
    hgt        = cy1 - cy0 + 18'sd1;

    // drop reads, fills and remaps that land outside the view or clip to nothing
    if ((op == OP_READ || op == OP_FILL || op == OP_REMAP) && (reject || empty_rect)) begin
      op = OP_NONE;
    end

    s1_nxt.op    = op;
    s1_nxt.x0    = cx0[14:0];
    s1_nxt.y0    = cy0[14:0];
    s1_nxt.w     = wdt[14:0];
    s1_nxt.h     = hgt[14:0];
    s1_nxt.color = color;
    s1_nxt.tidx  = table_index;
    s1_nxt.tval  = table_value;
  end

  assign in_ready  = !s1_v_r || job_ready;
  assign job_valid = s1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_r <= s1_nxt;
    end
  end

  always_comb begin
    row_off  = s1_r.y0 * cfg.stride;
    addr_sum = 32'(row_off) + 32'(cfg.base) + 32'(s1_r.x0);
    area     = s1_r.w * s1_r.h;
    job_addr = addr_sum[AW-1:0];

    job.op    = s1_r.op;
    job.w     = s1_r.w;
    job.h     = s1_r.h;
    job.color = s1_r.color;
    job.tidx  = s1_r.tidx;
    job.tval  = s1_r.tval;
    if (s1_r.op == OP_FILL || s1_r.op == OP_REMAP) begin
      job.count = (area > COUNT_LIMIT) ? COUNT_LIMIT[14:0] : area[14:0];
    end else begin
      job.count = '0;
    end
  end

endmodule

### sv/cbl_back.sv
// ----------------------------------------------------------------------------
// cbl_back: frame store sequencer
// Owns the frame store and remap table, zeroes the store and loads the
// table with identity after reset; walks clipped rectangles pixel by pixel.
// ----------------------------------------------------------------------------
module cbl_back import cbl_pkg::*; #(
  parameter int DEPTH = 16384,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  logic          job_valid,
  output logic          job_pop,
  input  job_t          job,
  input  logic [AW-1:0] job_addr,
  output logic          res_push,
  input  logic          res_full,
  output res_t          res,
  output logic          clearing
);

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_READ  = 8'b0000_0100,
    ST_FILL  = 8'b0000_1000,
    ST_RM_RD = 8'b0001_0000,
    ST_RM_TB = 8'b0010_0000,
    ST_RM_WR = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0] cur_r, cur_nxt, row_r, row_nxt, row_inc;
  logic [14:0]   col_r, col_nxt, rows_r, rows_nxt, w_r, w_nxt, h_r, h_nxt, count_r, count_nxt;
  logic [7:0]    color_r, color_nxt;
  logic          last_col, last_row;

  logic          f_we;
  logic [AW-1:0] f_waddr, f_raddr;
  logic [7:0]    f_wdata, f_rdata;
  logic          t_we;
  logic [7:0]    t_waddr, t_wdata, t_rdata;

  cbl_ram #(.W(8), .DEPTH(DEPTH), .AW(AW)) u_frame (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  cbl_ram #(.W(8), .DEPTH(256), .AW(8)) u_table (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (f_rdata),
    .rdata (t_rdata)
  );

  assign clearing = (state_r == ST_CLEAR);
  assign last_col = (col_r == w_r - 15'd1);
  assign last_row = (rows_r == h_r - 15'd1);
  assign row_inc  = row_r + AW'(cfg.stride);

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    cur_nxt     = cur_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    rows_nxt    = rows_r;
    w_nxt       = w_r;
    h_nxt       = h_r;
    count_nxt   = count_r;
    color_nxt   = color_r;
    f_we        = 1'b0;
    f_waddr     = cur_r;
    f_wdata     = color_r;
    f_raddr     = cur_r;
    t_we        = 1'b0;
    t_waddr     = job.tidx;
    t_wdata     = job.tval;
    job_pop     = 1'b0;
    res_push    = 1'b0;
    res.read_value     = '0;
    res.pixels_changed = count_r;

    // step to the next pixel; wrap to the next line at the right edge
    if (state_r == ST_FILL || state_r == ST_RM_WR) begin
      if (last_col) begin
        col_nxt  = '0;
        rows_nxt = rows_r + 15'd1;
        row_nxt  = row_inc;
        cur_nxt  = row_inc;
      end else begin
        col_nxt = col_r + 15'd1;
        cur_nxt = cur_r + 1'b1;
      end
    end

    case (state_r)
      ST_CLEAR: begin
        f_we        = 1'b1;
        f_waddr     = clr_cnt_r;
        f_wdata     = '0;
        if (clr_cnt_r[AW-1:8] == '0) begin
          t_we    = 1'b1;
          t_waddr = clr_cnt_r[7:0];
          t_wdata = clr_cnt_r[7:0];
        end
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (job_valid && !res_full) begin
          job_pop   = 1'b1;
          cur_nxt   = job_addr;
          row_nxt   = job_addr;
          col_nxt   = '0;
          rows_nxt  = '0;
          w_nxt     = job.w;
          h_nxt     = job.h;
          color_nxt = job.color;
          count_nxt = job.count;
          f_raddr   = job_addr;
          case (job.op)
            OP_READ:  state_nxt = ST_READ;
            OP_FILL:  state_nxt = ST_FILL;
            OP_REMAP: state_nxt = ST_RM_RD;
            OP_LOAD: begin
              t_we     = 1'b1;
              res_push = 1'b1;
              res.pixels_changed = '0;
            end
            default: begin
              res_push = 1'b1;
              res.pixels_changed = job.count;
            end
          endcase
        end
      end
      ST_READ: begin
        res_push           = 1'b1;
        res.read_value     = f_rdata;
        res.pixels_changed = '0;
        state_nxt          = ST_IDLE;
      end
      ST_FILL: begin
        f_we = 1'b1;
        if (last_col && last_row) begin
          state_nxt = ST_DONE;
        end
      end
      ST_RM_RD: begin
        state_nxt = ST_RM_TB;
      end
      ST_RM_TB: begin
        state_nxt = ST_RM_WR;
      end
      ST_RM_WR: begin
        f_we      = 1'b1;
        f_wdata   = t_rdata;
        state_nxt = (last_col && last_row) ? ST_DONE : ST_RM_RD;
      end
      ST_DONE: begin
        res_push  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    rows_r  <= rows_nxt;
    w_r     <= w_nxt;
    h_r     <= h_nxt;
    count_r <= count_nxt;
    color_r <= color_nxt;
  end

endmodule

### sv/clipped_rectangle_blitter.sv
// ----------------------------------------------------------------------------
// clipped_rectangle_blitter: clipped 8-bit rectangle blitter
// Pixel read/write, rectangle fill, viewport clear, table load and table remap over
// a byte-wide frame store with a configurable viewport.
//
//   port group   direction  handshake           payload
//   in_*         input      in_push / in_full   command, corners, spans, color, table
//   out_*        output     out_empty / out_pop read_value, pixels_changed
//   cfg_*        input      cfg_write_en        cfg_index, cfg_data
//
// Each command passes decode and clipping, then the sequencer: load and
// no-op report from idle, read fetches then reports, write and fill store
// each pixel then report, remap reads the frame, reads the table and writes
// back for each pixel then reports. After reset in_full stays high while
// the frame store is zeroed and the table is loaded with identity.
// A two-entry queue sits between clipping and the sequencer, and another
// holds results, so either side may stall until a queue fills without
// blocking the other. STORE_DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module clipped_rectangle_blitter import cbl_pkg::*; #(
  parameter int STORE_DEPTH = 16384
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [2:0]         in_command,
  input  logic signed [15:0] in_x,
  input  logic signed [15:0] in_y,
  input  logic signed [15:0] in_end_x,
  input  logic signed [15:0] in_end_y,
  input  logic signed [15:0] in_span_width,
  input  logic signed [15:0] in_span_height,
  input  logic [7:0]         in_color,
  input  logic [7:0]         in_table_index,
  input  logic [7:0]         in_table_value,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [7:0]         out_read_value,
  output logic [14:0]        out_pixels_changed,
  input  logic               cfg_write_en,
  input  logic [2:0]         cfg_index,
  input  logic [14:0]        cfg_data
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int JW = $bits(job_t) + AW;

  cfg_t          cfg_r;
  logic          front_ready, clearing;
  logic          job_valid, cmd_full, cmd_empty, job_pop;
  job_t          job_in, job_out;
  logic [AW-1:0] addr_in, addr_out;
  logic [JW-1:0] cmd_rdata;
  logic          res_push, res_full;
  res_t          res_in, res_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base     <= 14'd0;
      cfg_r.width    <= 15'd128;
      cfg_r.height   <= 15'd128;
      cfg_r.stride   <= 14'd128;
      cfg_r.remap_en <= 1'b1;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_BASE:     cfg_r.base     <= cfg_data[13:0];
        CFG_WIDTH:    cfg_r.width    <= cfg_data;
        CFG_HEIGHT:   cfg_r.height   <= cfg_data;
        CFG_STRIDE:   cfg_r.stride   <= cfg_data[13:0];
        CFG_REMAP_EN: cfg_r.remap_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // hold input off while the clearing pass runs or the front end is stalled
  assign in_full = clearing || !front_ready;

  cbl_front #(.AW(AW)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_push && !in_full),
    .in_ready    (front_ready),
    .command     (in_command),
    .x           (in_x),
    .y           (in_y),
    .end_x       (in_end_x),
    .end_y       (in_end_y),
    .span_width  (in_span_width),
    .span_height (in_span_height),
    .color       (in_color),
    .table_index (in_table_index),
    .table_value (in_table_value),
    .job_valid   (job_valid),
    .job_ready   (!cmd_full),
    .job         (job_in),
    .job_addr    (addr_in)
  );

  cbl_fifo #(.W(JW), .DEPTH(2)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_valid),
    .wdata ({job_in, addr_in}),
    .full  (cmd_full),
    .pop   (job_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  assign job_out  = job_t'(cmd_rdata[JW-1:AW]);
  assign addr_out = cmd_rdata[AW-1:0];

  cbl_back #(.DEPTH(STORE_DEPTH), .AW(AW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_valid (!cmd_empty),
    .job_pop   (job_pop),
    .job       (job_out),
    .job_addr  (addr_out),
    .res_push  (res_push),
    .res_full  (res_full),
    .res       (res_in),
    .clearing  (clearing)
  );

  cbl_fifo #(.W($bits(res_t)), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_out),
    .empty (out_empty)
  );

  assign out_read_value     = res_out.read_value;
  assign out_pixels_changed = res_out.pixels_changed;

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> in_full)
    else $error("input open during clearing pass");

  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> (!cmd_empty && !clearing))
    else $error("sequencer took a job from an empty queue");

endmodule

### tb/clipped_rectangle_blitter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clipped_rectangle_blitter_tb: self-checking bench of the rectangle blitter
// Drives pixel, rectangle, clear, remap, table and unused commands through the
// input queue. It predicts each result from a private copy of the frame
// store, remap table and viewport, and checks results in order as they are
// popped. Both sides idle at random. The viewport is changed between phases
// while the block is idle.
// ----------------------------------------------------------------------------
module clipped_rectangle_blitter_tb;
  import cbl_pkg::*;

  localparam int STORE_DEPTH = 16384;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  typedef struct {
    logic [2:0]         command;
    logic signed [15:0] x, y, end_x, end_y, span_w, span_h;
    logic [7:0]         color, tidx, tval;
  } blit_cmd_t;

  logic clk, rst_n;
  logic in_push, in_full;
  logic [2:0] in_command;
  logic signed [15:0] in_x, in_y, in_end_x, in_end_y, in_span_width, in_span_height;
  logic [7:0] in_color, in_table_index, in_table_value;
  logic out_empty, out_pop;
  logic [7:0] out_read_value;
  logic [14:0] out_pixels_changed;
  logic cfg_write_en;
  logic [2:0] cfg_index;
  logic [14:0] cfg_data;

  // private copy of the block state
  logic [7:0] pixels [STORE_DEPTH];
  logic [7:0] palette [256];
  int view_base, view_width, view_height, line_stride;
  bit remap_on;

  res_t results_due[$];
  int errors;
  bit quiet;

  clipped_rectangle_blitter #(.STORE_DEPTH(STORE_DEPTH)) dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int pixel_addr(int x, int y);
    longint a;
    a = longint'(view_base) + longint'(y) * line_stride + x;
    return int'(a % STORE_DEPTH);
  endfunction

  // clip an inclusive rectangle, fill or remap it; returns byte writes
  function automatic longint draw_rect(int x0, int y0, int x1, int y1, bit remap,
                                       logic [7:0] color);
    int a;
    longint w;
    if (x0 >= view_width || y0 >= view_height || x1 < 0 || y1 < 0) return 0;
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > view_width - 1) x1 = view_width - 1;
    if (y1 > view_height - 1) y1 = view_height - 1;
    if (x1 < x0 || y1 < y0) return 0;
    w = x1 - x0 + 1;
    for (int row = y0; row <= y1; row++) begin
      a = pixel_addr(x0, row);
      for (longint i = 0; i < w; i++) begin
        pixels[a] = remap ? palette[pixels[a]] : color;
        a = (a + 1) % STORE_DEPTH;
      end
    end
    return w * (y1 - y0 + 1);
  endfunction

  function automatic res_t blit_predict(blit_cmd_t c);
    res_t r;
    longint n;
    bit inb;
    n = 0;
    r.read_value = '0;
    inb = c.x >= 0 && c.y >= 0 && int'(c.x) < view_width && int'(c.y) < view_height;
    case (c.command)
      CMD_READ:  if (inb) r.read_value = pixels[pixel_addr(c.x, c.y)];
      CMD_WRITE: if (inb) begin
        pixels[pixel_addr(c.x, c.y)] = c.color;
        n = 1;
      end
      CMD_FILL:  n = draw_rect(c.x, c.y, c.end_x, c.end_y, 1'b0, c.color);
      CMD_REMAP: if (remap_on)
        n = draw_rect(c.x, c.y, int'(c.x) + int'(c.span_w) - 1,
                      int'(c.y) + int'(c.span_h) - 1, 1'b1, 8'd0);
      CMD_CLEAR: n = draw_rect(0, 0, view_width - 1, view_height - 1, 1'b0, c.color);
      CMD_LOAD:  palette[c.tidx] = c.tval;
      default: ;
    endcase
    if (n > STORE_DEPTH) n = STORE_DEPTH;
    r.pixels_changed = n[14:0];
    return r;
  endfunction

  // result checker and pop driver
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (results_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result rv=%0d pc=%0d",
                                   out_read_value, out_pixels_changed);
      end else begin
        want = results_due.pop_front();
        if (out_read_value !== want.read_value ||
            out_pixels_changed !== want.pixels_changed) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: read_value exp %0d got %0d, pixels_changed exp %0d got %0d",
                     want.read_value, out_read_value, want.pixels_changed,
                     out_pixels_changed);
        end
      end
    end
    out_pop <= quiet || ($urandom_range(99) >= 10);
  end

  task automatic send_cmd(blit_cmd_t c);
    if (!quiet && $urandom_range(99) < 10) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_command <= c.command;
    in_x <= c.x;
    in_y <= c.y;
    in_end_x <= c.end_x;
    in_end_y <= c.end_y;
    in_span_width <= c.span_w;
    in_span_height <= c.span_h;
    in_color <= c.color;
    in_table_index <= c.tidx;
    in_table_value <= c.tval;
    do @(posedge clk); while (in_full);
    results_due.push_back(blit_predict(c));
  endtask

  task automatic cmd(logic [2:0] op, int x = 0, int y = 0, int ex = 0, int ey = 0,
                     int sw = 0, int sh = 0, int color = 0, int ti = 0, int tv = 0);
    blit_cmd_t c;
    c.command = op;
    c.x = x; c.y = y; c.end_x = ex; c.end_y = ey;
    c.span_w = sw; c.span_h = sh;
    c.color = color; c.tidx = ti; c.tval = tv;
    send_cmd(c);
  endtask

  // drop push and let every outstanding command drain
  task automatic wait_idle();
    in_push <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_view(int base, int w, int h, int stride, bit en);
    int vals [5];
    vals = '{base, w, h, stride, int'(en)};
    wait_idle();
    for (int i = 0; i < 5; i++) begin
      cfg_write_en <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= 15'(vals[i]);
      @(posedge clk);
    end
    cfg_write_en <= 1'b0;
    view_base = base & 16'h3FFF;
    view_width = w & 16'h7FFF;
    view_height = h & 16'h7FFF;
    line_stride = stride & 16'h3FFF;
    remap_on = en;
  endtask

  function automatic logic [15:0] near(int lim);
    if ($urandom_range(99) < 15) return 16'($urandom);
    return 16'(int'($urandom_range(0, lim + 16)) - 8);
  endfunction

  task automatic send_random(bit huge);
    blit_cmd_t c;
    int r;
    r = $urandom_range(99);
    c.x = near(huge ? 64 : view_width);
    c.y = near(huge ? 64 : view_height);
    c.end_x = 16'(int'(c.x) + int'($urandom_range(0, 12)) - 2);
    c.end_y = 16'(int'(c.y) + int'($urandom_range(0, 12)) - 2);
    c.span_w = 16'(int'($urandom_range(0, 14)) - 2);
    c.span_h = 16'(int'($urandom_range(0, 14)) - 2);
    c.color = 8'($urandom);
    c.tidx = 8'($urandom);
    c.tval = 8'($urandom);
    if (!huge && $urandom_range(99) < 20) begin
      c.end_x = 16'($urandom);
      c.span_w = 16'($urandom);
    end
    if (!huge && $urandom_range(99) < 20) begin
      c.end_y = 16'($urandom);
      c.span_h = 16'($urandom);
    end
    if (r < 15) c.command = CMD_READ;
    else if (r < 35) c.command = CMD_WRITE;
    else if (r < 50) c.command = CMD_FILL;
    else if (r < 65) c.command = CMD_REMAP;
    else if (r < 69) c.command = huge ? CMD_READ : CMD_CLEAR;
    else if (r < 88) c.command = CMD_LOAD;
    else if (r < 92) c.command = $urandom_range(1) ? CMD_SPARE6 : CMD_SPARE7;
    else c.command = CMD_READ;
    send_cmd(c);
  endtask

  task automatic test_pixels();
    cmd(CMD_READ, 0, 0);
    cmd(CMD_WRITE, 0, 0, .color(255));
    cmd(CMD_WRITE, 127, 127, .color(8'hA5));
    cmd(CMD_WRITE, -1, 5, .color(1));
    cmd(CMD_WRITE, 128, 0, .color(1));
    cmd(CMD_WRITE, 32767, -32768, .color(1));
    cmd(CMD_READ, 0, 0);
    cmd(CMD_READ, 127, 127);
    cmd(CMD_READ, -32768, 32767);
    cmd(CMD_SPARE6, -1, -1, -1, -1, -1, -1, 255, 255, 255);
    cmd(CMD_SPARE7);
  endtask

  task automatic test_rects();
    cmd(CMD_FILL, -32768, 3, 32767, 4, .color(8'h5A));
    cmd(CMD_FILL, 10, 10, 9, 20, .color(7));
    cmd(CMD_FILL, 128, 0, 200, 5, .color(7));
    cmd(CMD_FILL, 0, -10, 5, -1, .color(7));
    cmd(CMD_LOAD, .ti(255), .tv(0));
    cmd(CMD_LOAD, .ti(8'h5A), .tv(255));
    cmd(CMD_LOAD, .ti(0), .tv(8'h11));
    cmd(CMD_REMAP, -3, 2, .sw(12), .sh(4));
    cmd(CMD_REMAP, 32767, 32767, .sw(32767), .sh(32767));
    cmd(CMD_REMAP, -32768, 3, .sw(-32768), .sh(2));
    cmd(CMD_READ, 0, 3);
    cmd(CMD_CLEAR, .color(8'h33));
    set_view(0, 128, 128, 128, 1'b0);
    cmd(CMD_REMAP, 0, 0, .sw(4), .sh(4));
    cmd(CMD_READ, 1, 1);
  endtask

  task automatic test_view_edges();
    set_view(16383, 0, 16384, 16383, 1'b1);
    cmd(CMD_CLEAR, .color(9));
    cmd(CMD_WRITE, 0, 0, .color(9));
    // overlapping lines, wrapped addresses, saturated count
    set_view(16380, 200, 100, 150, 1'b1);
    cmd(CMD_CLEAR, .color(8'h5A));
    set_view(16382, 8, 4, 3, 1'b1);
    cmd(CMD_REMAP, 0, 0, .sw(8), .sh(4));
    cmd(CMD_READ, 1, 1);
    set_view(8191, 16384, 16384, 16383, 1'b1);
    cmd(CMD_WRITE, 16383, 16383, .color(3));
    cmd(CMD_READ, 16383, 16383);
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 9) set_view(16383, 16384, 16384, 16383, 1'b1);
      else set_view($urandom_range(16383), $urandom_range(1, 24), $urandom_range(1, 24),
                    $urandom_range(1) ? $urandom_range(0, 30) : $urandom_range(16383),
                    phase != 4);
      quiet = (phase == 3);
      for (int i = 0; i < 105; i++) send_random(phase == 9);
      quiet = 1'b0;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_command = '0;
    in_x = '0; in_y = '0; in_end_x = '0; in_end_y = '0;
    in_span_width = '0; in_span_height = '0;
    in_color = '0; in_table_index = '0; in_table_value = '0;
    out_pop = 1'b0;
    cfg_write_en = 1'b0; cfg_index = '0; cfg_data = '0;
    errors = 0;
    quiet = 1'b0;
    for (int i = 0; i < STORE_DEPTH; i++) pixels[i] = '0;
    for (int i = 0; i < 256; i++) palette[i] = 8'(i);
    view_base = 0; view_width = 128; view_height = 128; line_stride = 128;
    remap_on = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_pixels();
    test_rects();
    test_view_edges();
    test_random();
    wait_idle();
    repeat (50) @(posedge clk);
    if (errors == 0 && results_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
